>>> design/assert_macros.svh
// Assertion macros used by the design core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, prop)

`define ASSERT_NEXT(label, clk, rst, pre, post)

`endif

`endif

>>> design/vva_pkg.sv
`timescale 1ns / 1ps

package vva_pkg;

  localparam int NUM_VOICES_DEF = 16;
  localparam int GEN_BITS_DEF = 4;
  localparam int ALU_W = 17;

  localparam logic [2:0] OP_PLAY = 3'd0;
  localparam logic [2:0] OP_TOUCH = 3'd1;
  localparam logic [2:0] OP_STOP = 3'd2;
  localparam logic [2:0] OP_FLIP = 3'd3;
  localparam logic [2:0] OP_STOP_ALL = 3'd4;
  localparam logic [2:0] OP_QUERY = 3'd5;

  localparam logic [2:0] ACT_NONE = 3'd0;
  localparam logic [2:0] ACT_START = 3'd1;
  localparam logic [2:0] ACT_RESUME = 3'd2;
  localparam logic [2:0] ACT_UPDATE = 3'd3;
  localparam logic [2:0] ACT_FADE = 3'd4;
  localparam logic [2:0] ACT_PAUSE_REL = 3'd5;
  localparam logic [2:0] ACT_HALT_ALL = 3'd6;
  localparam logic [2:0] ACT_DONE = 3'd7;

  localparam logic [1:0] ALU_ADD = 2'd0;
  localparam logic [1:0] ALU_SUB = 2'd1;
  localparam logic [1:0] ALU_EQ = 2'd2;

  typedef struct packed {
    logic [2:0]  operation;
    logic        handle_present;
    logic [7:0]  handle;
    logic [15:0] sound_id;
    logic        sound_ok;
    logic        voice_paused;
    logic        voice_playing;
  } in_t;

  typedef struct packed {
    logic [2:0] action;
    logic [3:0] voice;
    logic [7:0] handle_out;
    logic       handle_good;
    logic       is_playing;
    logic       last;
  } out_t;

  typedef struct packed {
    logic valid;
    out_t data;
  } emit_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] y;
    logic             eq;
  } alu_rsp_t;

endpackage

>>> design/vva_alu.sv
`timescale 1ns / 1ps

module vva_alu (
  input  vva_pkg::alu_req_t req,
  output vva_pkg::alu_rsp_t rsp
);
  import vva_pkg::*;

  always_comb begin
    rsp.eq = (req.a == req.b);
    unique case (req.op)
      ALU_ADD: rsp.y = req.a + req.b;
      ALU_SUB: rsp.y = req.a - req.b;
      default: rsp.y = '0;
    endcase
  end

endmodule

>>> design/vva_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vva_core #(
  parameter int NUM_VOICES = vva_pkg::NUM_VOICES_DEF,
  parameter int GEN_BITS = vva_pkg::GEN_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  vva_pkg::in_t   req,
  input  logic           start,
  output logic           idle,
  input  logic           slot_free,
  output vva_pkg::emit_t emit
);
  import vva_pkg::*;

  localparam int VW = $clog2(NUM_VOICES);
  localparam int CW = $clog2(NUM_VOICES + 1);
  localparam logic [CW-1:0] FULL = CW'(NUM_VOICES);
  localparam logic [VW-1:0] LAST_V = VW'(NUM_VOICES - 1);
  localparam logic [7:0] NV8 = 8'(NUM_VOICES);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_CHK = 4'd1;
  localparam logic [3:0] ST_BND = 4'd2;
  localparam logic [3:0] ST_STOP = 4'd3;
  localparam logic [3:0] ST_POP = 4'd4;
  localparam logic [3:0] ST_STK = 4'd5;
  localparam logic [3:0] ST_GINC = 4'd6;
  localparam logic [3:0] ST_SCAN = 4'd7;
  localparam logic [3:0] ST_SEND_A = 4'd8;
  localparam logic [3:0] ST_SEND_B = 4'd9;

  logic [3:0]            state;
  in_t                   rq;
  logic [VW-1:0]         idx;
  logic                  rng;
  logic [VW-1:0]         cnt;
  out_t                  res_a;
  out_t                  res_b;
  logic                  two;
  logic [CW-1:0]         count;
  logic [NUM_VOICES-1:0] in_free;
  logic [NUM_VOICES-1:0] live_now;
  logic [NUM_VOICES-1:0] live_prev;
  logic [NUM_VOICES-1:0] gen_vld;
  logic [NUM_VOICES-1:0] bnd_vld;
  logic [NUM_VOICES-1:0] stk_vld;

  logic [GEN_BITS-1:0] gen_mem [NUM_VOICES];
  logic [15:0]         bnd_mem [NUM_VOICES];
  logic [VW-1:0]       stk_mem [NUM_VOICES];

  logic [GEN_BITS-1:0] gen_q;
  logic                gen_qv;
  logic [15:0]         bnd_q;
  logic                bnd_qv;
  logic [VW-1:0]       stk_q;
  logic                stk_qv;
  logic [VW-1:0]       stk_qa;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic [7:0]          req_hv;
  logic [VW-1:0]       req_idx;
  logic [GEN_BITS-1:0] gen_val;
  logic [16:0]         bnd_val;
  logic [VW-1:0]       stk_val;
  logic                live_any;
  logic                cur;
  logic                rel;
  logic                b_eq;
  logic                restart;
  logic [GEN_BITS-1:0] new_gen;
  logic [7:0]          fresh_hid;
  logic [VW-1:0]       push_idx;
  logic                push_can;
  logic                push_do;
  logic                gen_we;
  logic                bnd_we;
  logic                gen_re;
  logic [VW-1:0]       gen_ra;
  logic [VW-1:0]       stk_wa;

  function automatic out_t mk(input logic [2:0] act, input logic [VW-1:0] v,
                              input logic [7:0] h, input logic good,
                              input logic play, input logic fin);
    out_t r;
    logic [7:0] w;
    w = 8'(v);
    r.action = act;
    r.voice = w[3:0];
    r.handle_out = h;
    r.handle_good = good;
    r.is_playing = play;
    r.last = fin;
    return r;
  endfunction

  vva_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign req_hv = req.handle >> GEN_BITS;
  assign req_idx = req_hv[VW-1:0];
  assign gen_val = gen_qv ? gen_q : '0;
  assign bnd_val = bnd_qv ? {1'b1, bnd_q} : 17'd0;
  assign stk_val = stk_qv ? stk_q : stk_qa;
  assign live_any = live_now[idx] | live_prev[idx];
  assign cur = rq.handle_present & rng & alu_rsp.eq;
  assign rel = ~live_now[cnt] & live_prev[cnt];
  assign b_eq = alu_rsp.eq;
  assign restart = ~(b_eq & (rq.voice_paused | rq.voice_playing));
  assign new_gen = alu_rsp.y[GEN_BITS-1:0];
  assign fresh_hid = (8'(idx) << GEN_BITS) | 8'(new_gen);
  assign push_idx = (state == ST_STOP) ? idx : cnt;
  assign push_can = ~in_free[push_idx] & (count < FULL);
  assign push_do = push_can & ((state == ST_STOP) | ((state == ST_SCAN) & rel & slot_free));
  assign gen_we = (state == ST_GINC);
  assign bnd_we = ((state == ST_BND) & restart) | (state == ST_GINC);
  assign gen_re = start | (state == ST_STK);
  assign gen_ra = (state == ST_STK) ? stk_val : req_idx;
  assign stk_wa = count[VW-1:0];
  assign idle = (state == ST_IDLE);

  always_comb begin
    alu_req.op = ALU_EQ;
    alu_req.a = '0;
    alu_req.b = '0;
    case (state)
      ST_CHK: begin
        alu_req.a = ALU_W'(gen_val);
        alu_req.b = ALU_W'(rq.handle[GEN_BITS-1:0]);
      end
      ST_BND: begin
        alu_req.a = ALU_W'(bnd_val);
        alu_req.b = ALU_W'({1'b1, rq.sound_id});
      end
      ST_STOP, ST_SCAN: begin
        alu_req.op = ALU_ADD;
        alu_req.a = ALU_W'(count);
        alu_req.b = ALU_W'(1);
      end
      ST_POP: begin
        alu_req.op = ALU_SUB;
        alu_req.a = ALU_W'(count);
        alu_req.b = ALU_W'(1);
      end
      ST_GINC: begin
        alu_req.op = ALU_ADD;
        alu_req.a = ALU_W'(gen_val);
        alu_req.b = ALU_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    emit.valid = 1'b0;
    emit.data = res_a;
    case (state)
      ST_SCAN: begin
        emit.valid = rel & slot_free;
        emit.data = mk(ACT_PAUSE_REL, cnt, 8'd0, 1'b0, 1'b0, 1'b0);
      end
      ST_SEND_A: emit.valid = slot_free;
      ST_SEND_B: begin
        emit.valid = slot_free;
        emit.data = res_b;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (gen_we) begin
      gen_mem[idx] <= new_gen;
    end
    if (bnd_we) begin
      bnd_mem[idx] <= rq.sound_id;
    end
    if (push_do) begin
      stk_mem[stk_wa] <= push_idx;
    end
    if (gen_re) begin
      gen_q <= gen_mem[gen_ra];
      gen_qv <= gen_vld[gen_ra];
    end
    if (start) begin
      bnd_q <= bnd_mem[req_idx];
      bnd_qv <= bnd_vld[req_idx];
    end
    if (state == ST_POP) begin
      stk_q <= stk_mem[alu_rsp.y[VW-1:0]];
      stk_qv <= stk_vld[alu_rsp.y[VW-1:0]];
      stk_qa <= alu_rsp.y[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= FULL;
      in_free <= '1;
      live_now <= '0;
      live_prev <= '0;
      gen_vld <= '0;
      bnd_vld <= '0;
      stk_vld <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            rq <= req;
            idx <= req_idx;
            rng <= (req_hv < NV8);
            two <= 1'b0;
            cnt <= '0;
            unique case (req.operation) inside
              OP_STOP_ALL: begin
                count <= FULL;
                in_free <= '1;
                live_now <= '0;
                live_prev <= '0;
                gen_vld <= '0;
                bnd_vld <= '0;
                stk_vld <= '0;
                res_a <= mk(ACT_HALT_ALL, '0, 8'd0, 1'b0, 1'b0, 1'b1);
                state <= ST_SEND_A;
              end
              OP_FLIP: state <= ST_SCAN;
              OP_PLAY, OP_TOUCH, OP_STOP, OP_QUERY: state <= ST_CHK;
              default: begin
                res_a <= mk(ACT_NONE, '0, 8'd0, 1'b0, 1'b0, 1'b1);
                state <= ST_SEND_A;
              end
            endcase
          end
        end
        ST_CHK: begin
          unique case (rq.operation)
            OP_PLAY: begin
              if (!rq.sound_ok) begin
                res_a <= mk(ACT_DONE, '0, 8'd0, 1'b0, 1'b0, 1'b1);
                state <= ST_SEND_A;
              end else if (cur && live_any) begin
                state <= ST_BND;
              end else if (count == '0) begin
                res_a <= mk(ACT_DONE, '0, 8'd0, 1'b0, 1'b0, 1'b1);
                state <= ST_SEND_A;
              end else begin
                state <= ST_POP;
              end
            end
            OP_TOUCH: begin
              state <= ST_SEND_A;
              if (cur) begin
                live_now[idx] <= 1'b1;
                res_a <= mk(ACT_UPDATE, idx, 8'd0, 1'b0, 1'b0, 1'b1);
              end else begin
                res_a <= mk(ACT_NONE, '0, 8'd0, 1'b0, 1'b0, 1'b1);
              end
            end
            OP_STOP: begin
              if (cur) begin
                state <= ST_STOP;
              end else begin
                res_a <= mk(ACT_NONE, '0, 8'd0, 1'b0, 1'b0, 1'b1);
                state <= ST_SEND_A;
              end
            end
            OP_QUERY: begin
              res_a <= mk(ACT_DONE, '0, 8'd0, 1'b0, cur & rq.voice_playing, 1'b1);
              state <= ST_SEND_A;
            end
            default: begin
              res_a <= mk(ACT_NONE, '0, 8'd0, 1'b0, 1'b0, 1'b1);
              state <= ST_SEND_A;
            end
          endcase
        end
        ST_BND: begin
          live_now[idx] <= 1'b1;
          state <= ST_SEND_A;
          if (b_eq && rq.voice_paused) begin
            res_a <= mk(ACT_RESUME, idx, rq.handle, 1'b1, 1'b0, 1'b0);
            res_b <= mk(ACT_UPDATE, idx, rq.handle, 1'b1, 1'b0, 1'b1);
            two <= 1'b1;
          end else if (b_eq && rq.voice_playing) begin
            res_a <= mk(ACT_UPDATE, idx, rq.handle, 1'b1, 1'b0, 1'b1);
          end else begin
            res_a <= mk(ACT_START, idx, rq.handle, 1'b1, 1'b0, 1'b0);
            res_b <= mk(ACT_UPDATE, idx, rq.handle, 1'b1, 1'b0, 1'b1);
            two <= 1'b1;
          end
        end
        ST_STOP: begin
          if (push_do) begin
            count <= alu_rsp.y[CW-1:0];
            in_free[idx] <= 1'b1;
          end
          live_now[idx] <= 1'b0;
          live_prev[idx] <= 1'b0;
          bnd_vld[idx] <= 1'b0;
          res_a <= mk(ACT_FADE, idx, 8'd0, 1'b0, 1'b0, 1'b1);
          state <= ST_SEND_A;
        end
        ST_POP: begin
          count <= alu_rsp.y[CW-1:0];
          state <= ST_STK;
        end
        ST_STK: begin
          idx <= stk_val;
          in_free[stk_val] <= 1'b0;
          state <= ST_GINC;
        end
        ST_GINC: begin
          live_now[idx] <= 1'b1;
          res_a <= mk(ACT_START, idx, fresh_hid, 1'b1, 1'b0, 1'b0);
          res_b <= mk(ACT_UPDATE, idx, fresh_hid, 1'b1, 1'b0, 1'b1);
          two <= 1'b1;
          state <= ST_SEND_A;
        end
        ST_SCAN: begin
          if (push_do) begin
            count <= alu_rsp.y[CW-1:0];
            in_free[cnt] <= 1'b1;
          end
          if (!rel || slot_free) begin
            if (cnt == LAST_V) begin
              live_prev <= live_now;
              live_now <= '0;
              res_a <= mk(ACT_DONE, '0, 8'd0, 1'b0, 1'b0, 1'b1);
              state <= ST_SEND_A;
            end else begin
              cnt <= cnt + VW'(1);
            end
          end
        end
        ST_SEND_A: begin
          if (slot_free) begin
            state <= two ? ST_SEND_B : ST_IDLE;
          end
        end
        ST_SEND_B: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (gen_we) begin
        gen_vld[idx] <= 1'b1;
      end
      if (bnd_we) begin
        bnd_vld[idx] <= 1'b1;
      end
      if (push_do) begin
        stk_vld[stk_wa] <= 1'b1;
      end
    end
  end

  `ASSERT_ALWAYS(a_count_range, clk, rst, count <= FULL)
  `ASSERT_ALWAYS(a_free_match, clk, rst, (state != ST_STK) |-> ($countones(in_free) == int'(count)))
  `ASSERT_ALWAYS(a_pop_free, clk, rst, (state == ST_STK) |-> in_free[stk_val])
  `ASSERT_NEXT(a_last_idle, clk, rst, emit.valid && emit.data.last, state == ST_IDLE)

endmodule

>>> design/versioned_voice_allocator.sv
`timescale 1ns / 1ps

// Voice allocator that hands out mixer voices through handles of a voice number and a
// generation count. Requests are taken one at a time and answered with one or more
// result transfers, the final one marked by last. A small sequencer drives one shared
// add and compare unit and registered-read tables for generations, bound sounds and the
// free stack; a frame flip walks every voice, and the sequencer waits whenever the result
// side stalls. A stop-all clears every table at once through per-entry valid flags, so no
// clearing pass follows reset. The next request is accepted while the last result still
// waits in the output register.
module versioned_voice_allocator #(
  parameter int NUM_VOICES = vva_pkg::NUM_VOICES_DEF,
  parameter int GEN_BITS = vva_pkg::GEN_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  vva_pkg::in_t  req,
  output logic          res_valid,
  input  logic          res_ready,
  output vva_pkg::out_t res
);
  import vva_pkg::*;

  logic  idle;
  logic  start;
  logic  slot_free;
  emit_t emit;

  assign req_ready = idle;
  assign start = req_valid & idle;
  assign slot_free = ~res_valid | res_ready;

  vva_core #(
    .NUM_VOICES (NUM_VOICES),
    .GEN_BITS   (GEN_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .start     (start),
    .idle      (idle),
    .slot_free (slot_free),
    .emit      (emit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit.valid) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      res <= emit.data;
    end
  end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import vva_pkg::*;

  localparam int NV = NUM_VOICES_DEF;
  localparam int GB = GEN_BITS_DEF;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  typedef enum logic [1:0] {AIM_AS_IS, AIM_LIVE, AIM_STALE, AIM_RECENT} aim_t;

  typedef struct {
    in_t  item;
    aim_t aim;
    bit   same_sound;
    bit   drain;
  } request_plan_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  in_t  req = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  out_t res;
  logic calm = 1'b0;

  request_plan_t pending_plans[$];
  out_t expected_actions[$];

  int unsigned free_list[NV];
  int unsigned free_depth;
  logic [GB-1:0] gen[NV];
  bit live_now[NV];
  bit live_prev[NV];
  bit in_free[NV];
  logic [16:0] bound[NV];
  logic [7:0] last_handle = '0;

  int plans_made = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int flips = 0;
  int refused_plays = 0;
  int mismatches = 0;
  int send_gap = 0;
  int stall_left = 0;

  versioned_voice_allocator i_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void clear_voices();
    for (int i = 0; i < NV; i++) begin
      free_list[i] = i;
      gen[i] = '0;
      live_now[i] = 1'b0;
      live_prev[i] = 1'b0;
      in_free[i] = 1'b1;
      bound[i] = '0;
    end
    free_depth = NV;
  endfunction

  function automatic void release_voice(int unsigned v);
    if (v >= NV || in_free[v] || free_depth >= NV) return;
    free_list[free_depth] = v;
    free_depth++;
    in_free[v] = 1'b1;
  endfunction

  function automatic void note_result(logic [2:0] act, int unsigned v, logic [7:0] h,
                                      logic good, logic playing, logic fin);
    out_t o;
    o.action = act;
    o.voice = v[3:0];
    o.handle_out = h;
    o.handle_good = good;
    o.is_playing = playing;
    o.last = fin;
    expected_actions.insert(expected_actions.size(), o);
  endfunction

  function automatic void predict_voice_actions(in_t r);
    int unsigned v;
    logic cur;
    logic reuse;
    logic [7:0] hid;
    logic [16:0] want;
    v = r.handle >> GB;
    cur = r.handle_present && v < NV && gen[v] == r.handle[GB-1:0];
    want = {1'b1, r.sound_id};
    case (r.operation)
      OP_PLAY: begin
        if (!r.sound_ok) begin
          refused_plays++;
          note_result(ACT_DONE, 0, 8'd0, 1'b0, 1'b0, 1'b1);
          return;
        end
        reuse = 1'b0;
        hid = r.handle;
        if (cur && (live_now[v] || live_prev[v])) begin
          reuse = 1'b1;
          if (bound[v] == want && (r.voice_paused || r.voice_playing)) begin
            live_now[v] = 1'b1;
            if (r.voice_paused) note_result(ACT_RESUME, v, hid, 1'b1, 1'b0, 1'b0);
            note_result(ACT_UPDATE, v, hid, 1'b1, 1'b0, 1'b1);
            return;
          end
        end
        if (!reuse) begin
          if (free_depth == 0) begin
            refused_plays++;
            note_result(ACT_DONE, 0, 8'd0, 1'b0, 1'b0, 1'b1);
            return;
          end
          free_depth--;
          v = free_list[free_depth];
          in_free[v] = 1'b0;
          gen[v] = gen[v] + 1'b1;
          hid = 8'((v << GB) | gen[v]);
          last_handle = hid;
        end
        bound[v] = want;
        live_now[v] = 1'b1;
        note_result(ACT_START, v, hid, 1'b1, 1'b0, 1'b0);
        note_result(ACT_UPDATE, v, hid, 1'b1, 1'b0, 1'b1);
      end
      OP_TOUCH: begin
        if (!cur) begin
          note_result(ACT_NONE, 0, 8'd0, 1'b0, 1'b0, 1'b1);
        end else begin
          live_now[v] = 1'b1;
          note_result(ACT_UPDATE, v, 8'd0, 1'b0, 1'b0, 1'b1);
        end
      end
      OP_STOP: begin
        if (!cur) begin
          note_result(ACT_NONE, 0, 8'd0, 1'b0, 1'b0, 1'b1);
        end else begin
          release_voice(v);
          live_now[v] = 1'b0;
          live_prev[v] = 1'b0;
          bound[v] = '0;
          note_result(ACT_FADE, v, 8'd0, 1'b0, 1'b0, 1'b1);
        end
      end
      OP_FLIP: begin
        flips++;
        for (int i = 0; i < NV; i++) begin
          if (!live_now[i] && live_prev[i]) begin
            note_result(ACT_PAUSE_REL, i, 8'd0, 1'b0, 1'b0, 1'b0);
            release_voice(i);
          end
        end
        for (int i = 0; i < NV; i++) begin
          live_prev[i] = live_now[i];
          live_now[i] = 1'b0;
        end
        note_result(ACT_DONE, 0, 8'd0, 1'b0, 1'b0, 1'b1);
      end
      OP_STOP_ALL: begin
        clear_voices();
        note_result(ACT_HALT_ALL, 0, 8'd0, 1'b0, 1'b0, 1'b1);
      end
      OP_QUERY: note_result(ACT_DONE, 0, 8'd0, 1'b0, cur && r.voice_playing, 1'b1);
      default: note_result(ACT_NONE, 0, 8'd0, 1'b0, 1'b0, 1'b1);
    endcase
  endfunction

  // Handles are chosen when the request goes out, so they track the voices in use then.
  function automatic in_t aim_request(request_plan_t p);
    in_t r;
    int unsigned taken[$];
    int unsigned v;
    logic [GB-1:0] g;
    r = p.item;
    if (p.aim == AIM_RECENT) begin
      r.handle_present = 1'b1;
      r.handle = last_handle;
    end else if (p.aim != AIM_AS_IS) begin
      for (int i = 0; i < NV; i++) begin
        if (!in_free[i]) taken.insert(taken.size(), i);
      end
      if (taken.size() > 0) begin
        v = taken[$urandom_range(0, taken.size() - 1)];
        g = (p.aim == AIM_STALE) ? gen[v] - 1'b1 : gen[v];
        r.handle_present = 1'b1;
        r.handle = 8'((v << GB) | g);
      end
    end
    if (p.aim != AIM_AS_IS && p.same_sound) begin
      v = r.handle >> GB;
      if (bound[v][16]) r.sound_id = bound[v][15:0];
    end
    return r;
  endfunction

  function automatic void queue_request(logic [2:0] op, logic present, logic [7:0] h,
                                        logic [15:0] snd, logic ok, logic paused,
                                        logic playing, aim_t aim, bit same, bit drain);
    request_plan_t p;
    p.item.operation = op;
    p.item.handle_present = present;
    p.item.handle = h;
    p.item.sound_id = snd;
    p.item.sound_ok = ok;
    p.item.voice_paused = paused;
    p.item.voice_playing = playing;
    p.aim = aim;
    p.same_sound = same;
    p.drain = drain;
    pending_plans.insert(pending_plans.size(), p);
    plans_made++;
  endfunction

  function automatic void queue_random(logic [2:0] op, aim_t aim, bit drain);
    queue_request(op, 1'($urandom_range(0, 1)), 8'($urandom), 16'($urandom),
                  $urandom_range(0, 7) != 0, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), aim, 1'($urandom_range(0, 1)), drain);
  endfunction

  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) calm <= !calm;
  end

  always @(posedge clk) begin : drive_requests
    logic hold_valid;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      hold_valid = req_valid;
      if (req_valid && req_ready) begin
        predict_voice_actions(req);
        requests_sent++;
        hold_valid = 1'b0;
        send_gap = calm ? 0 : idle_span();
      end
      if (!hold_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_plans.size() > 0 &&
                     (!pending_plans[0].drain || expected_actions.size() == 0)) begin
          req <= aim_request(pending_plans.pop_front());
          hold_valid = 1'b1;
        end
      end
      req_valid <= hold_valid;
    end
  end

  always @(posedge clk) begin : check_results
    out_t want;
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        results_seen++;
        if (expected_actions.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result transfer: %p", res);
        end else begin
          want = expected_actions.pop_front();
          if (res.action !== want.action || res.voice !== want.voice ||
              res.handle_out !== want.handle_out || res.handle_good !== want.handle_good ||
              res.is_playing !== want.is_playing || res.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) $display("Result mismatch: expected %p, got %p", want, res);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
        if (!calm && $urandom_range(0, 4) == 0) stall_left = idle_span();
      end
    end
  end

  initial begin : stimulus
    int k;
    clear_voices();

    queue_request(OP_QUERY, 0, 8'hFF, 16'hFFFF, 1, 1, 1, AIM_AS_IS, 0, 0);
    queue_request(OP_TOUCH, 0, 8'h00, 16'h0000, 1, 0, 0, AIM_AS_IS, 0, 0);
    queue_request(OP_STOP, 0, 8'hF1, 16'h0000, 1, 0, 0, AIM_AS_IS, 0, 0);
    queue_request(OP_PLAY, 1, 8'hF1, 16'h0000, 0, 0, 0, AIM_AS_IS, 0, 0);
    queue_request(OP_PLAY, 0, 8'h00, 16'h0000, 1, 0, 0, AIM_AS_IS, 0, 0);
    queue_request(OP_PLAY, 0, 8'hFF, 16'hFFFF, 1, 1, 1, AIM_AS_IS, 0, 0);
    queue_request(OP_TOUCH, 1, 8'hF1, 16'h0000, 1, 0, 0, AIM_AS_IS, 0, 0);
    queue_request(OP_QUERY, 1, 8'hF1, 16'h0000, 1, 0, 1, AIM_AS_IS, 0, 0);
    queue_request(OP_QUERY, 1, 8'hF0, 16'h0000, 1, 0, 1, AIM_AS_IS, 0, 0);
    queue_request(OP_PLAY, 1, 8'hF1, 16'h0000, 1, 1, 0, AIM_AS_IS, 0, 0);
    queue_request(OP_PLAY, 1, 8'hF1, 16'h0000, 1, 0, 1, AIM_AS_IS, 0, 0);
    queue_request(OP_PLAY, 1, 8'hF1, 16'h0000, 1, 0, 0, AIM_AS_IS, 0, 0);
    queue_request(OP_PLAY, 1, 8'hE1, 16'h1234, 1, 0, 1, AIM_AS_IS, 0, 0);
    queue_request(OP_STOP, 1, 8'hE1, 16'h0000, 1, 0, 0, AIM_AS_IS, 0, 0);
    queue_request(OP_STOP, 1, 8'hE1, 16'h0000, 1, 0, 0, AIM_AS_IS, 0, 0);
    queue_request(OP_TOUCH, 1, 8'hE1, 16'h0000, 1, 0, 0, AIM_AS_IS, 0, 0);
    queue_request(OP_FLIP, 0, 8'h00, 16'h0000, 1, 0, 0, AIM_AS_IS, 0, 0);
    queue_request(OP_FLIP, 0, 8'h00, 16'h0000, 1, 0, 0, AIM_AS_IS, 0, 0);
    queue_request(OP_RSVD6, 1, 8'hF1, 16'h0000, 1, 0, 0, AIM_AS_IS, 0, 0);
    queue_request(OP_RSVD7, 1, 8'hF1, 16'h0000, 1, 0, 0, AIM_AS_IS, 0, 0);
    queue_request(OP_STOP_ALL, 0, 8'h00, 16'h0000, 1, 0, 0, AIM_AS_IS, 0, 0);
    queue_request(OP_QUERY, 1, 8'h00, 16'h0000, 1, 0, 1, AIM_AS_IS, 0, 0);
    queue_request(OP_TOUCH, 1, 8'h00, 16'h0000, 1, 0, 0, AIM_AS_IS, 0, 0);

    // Random phase: mostly frames of plays and touches on voices in use, ended by flips.
    queue_random(OP_FLIP, AIM_AS_IS, 1);
    while (plans_made < 180) begin
      if (plans_made == 80) begin
        // Repeated allocate and stop of one voice walks its generation through a wrap.
        queue_request(OP_STOP_ALL, 0, 8'h00, 16'h0000, 1, 0, 0, AIM_AS_IS, 0, 1);
        for (int i = 0; i < 17; i++) begin
          queue_request(OP_PLAY, 0, 8'($urandom), 16'($urandom), 1, 0, 0, AIM_AS_IS, 0, 0);
          queue_request(OP_STOP, 0, 8'h00, 16'h0000, 1, 0, 0, AIM_RECENT, 0, 0);
        end
      end else if (plans_made == 150) begin
        // More fresh plays than voices, so the last ones find no free voice.
        for (int i = 0; i < 17; i++) begin
          queue_request(OP_PLAY, 0, 8'($urandom), 16'($urandom), 1, 0, 0, AIM_AS_IS, 0,
                        i == 0);
        end
      end else begin
        k = $urandom_range(0, 99);
        if (k < 22) queue_random(OP_PLAY, AIM_LIVE, $urandom_range(0, 24) == 0);
        else if (k < 28) queue_random(OP_PLAY, AIM_STALE, 0);
        else if (k < 34) queue_random(OP_PLAY, AIM_AS_IS, 0);
        else if (k < 50) queue_random(OP_TOUCH, AIM_LIVE, 0);
        else if (k < 57) queue_random(OP_STOP, AIM_LIVE, 0);
        else if (k < 62) queue_random(OP_STOP, AIM_STALE, 0);
        else if (k < 70) queue_random(OP_QUERY, AIM_LIVE, 0);
        else if (k < 73) queue_random(OP_QUERY, AIM_STALE, 0);
        else if (k < 86) queue_random(OP_FLIP, AIM_AS_IS, $urandom_range(0, 9) == 0);
        else if (k < 88) queue_random(OP_STOP_ALL, AIM_AS_IS, 0);
        else queue_random(3'($urandom_range(0, 7)), AIM_AS_IS, 0);
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (requests_sent < plans_made || expected_actions.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d requests, including %0d frame flips and %0d refused plays;",
             requests_sent, flips, refused_plays);
    $display("checked %0d result transfers, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0 && expected_actions.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Timeout with %0d requests sent and %0d results still due.",
             requests_sent, expected_actions.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
